FILE: sv/murmur3_two_lane_hash64_macros.svh
// Assertion macros for the two-lane 64-bit hash block.
`ifndef MURMUR3_TWO_LANE_HASH64_MACROS_SVH
`define MURMUR3_TWO_LANE_HASH64_MACROS_SVH

// Check that pre at one edge implies post at the next edge.
`define M3H_ASSERT_NEXT(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("hash block port property violated");

// Check that pre implies post at the same edge.
`define M3H_ASSERT_NOW(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("hash block port property violated");

`endif

FILE: sv/m3h64_pkg.sv
// Package with widths and mixing constants of the two-lane hash block.
package m3h64_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int BLOCK_W = 64;
    localparam int FILL_W  = 3;

    localparam logic [WORD_W-1:0] MIX_C1 = 32'h239b961b;
    localparam logic [WORD_W-1:0] MIX_C2 = 32'hab0e9789;
    localparam logic [WORD_W-1:0] MIX_C3 = 32'h561ccd1b;
    localparam logic [WORD_W-1:0] MIX_C4 = 32'h0bcaa747;
    localparam logic [WORD_W-1:0] FIN_C5 = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] FIN_C6 = 32'hc2b2ae35;
    localparam logic [WORD_W-1:0] LANE_MUL = 32'd5;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t mul_a;
        word_t mul_b;
        word_t add_c;
    } mac_op_t;

endpackage

FILE: sv/murmur3_two_lane_hash64.sv
// Top level of the two-lane 64-bit hash block with its step sequencer.
//
//  channel   direction  handshake                  payload
//  in        sink       in_valid / in_ready        byte_value, has_byte, last
//  out       source     out_valid / out_ready      hash_value
//  cfg       sink       cfg_wr_en                  cfg_wr_data (seed)
//
// A transaction that neither completes a block nor is last leaves the block idle.
// One that completes an 8-byte block then runs the block mix steps on the shared multiply-add unit.
// The last transaction of a string then runs the finalizer steps, in part on that unit.
// The result waits in an output register; the final step holds while it is not taken.
// Reset clears the lanes, the block buffer, the counters and the seed.
module murmur3_two_lane_hash64
    import m3h64_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic                has_byte,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BLOCK_W-1:0]  hash_value,
    input  logic                cfg_wr_en,
    input  logic [WORD_W-1:0]   cfg_wr_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIX  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] MIX_LAST = 4'd5;
    localparam logic [STEP_W-1:0] FIN_LAST = 4'd12;

    logic [1:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    word_t               seed_reg, seed_next;
    word_t               h1_reg, h1_next;
    word_t               h2_reg, h2_next;
    word_t               k_reg, k_next;
    word_t               len_reg, len_next;
    logic [BLOCK_W-1:0]  block_reg, block_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                open_reg, open_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0]  hash_reg, hash_next;

    mac_op_t             mac_op;
    word_t               mac_y;
    word_t               blk_lo, blk_hi;
    word_t               t1, t2;
    logic                in_fire;

    function automatic word_t rotl(input word_t x, input int unsigned r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    m3h64_mac u_mac (
        .op     (mac_op),
        .result (mac_y)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign hash_value = hash_reg;
    assign blk_lo    = block_reg[WORD_W-1:0];
    assign blk_hi    = block_reg[BLOCK_W-1:WORD_W];

    always_comb
    begin
        mac_op = '0;
        t1     = '0;
        t2     = '0;
        unique case (state_reg)
            ST_MIX:
            begin
                unique case (step_reg)
                    4'd0: mac_op = '{blk_lo, MIX_C1, '0};
                    4'd1: mac_op = '{rotl(k_reg, 15), MIX_C2, '0};
                    4'd2: mac_op = '{rotl(h1_reg ^ k_reg, 19) + h2_reg, LANE_MUL, MIX_C3};
                    4'd3: mac_op = '{blk_hi, MIX_C2, '0};
                    4'd4: mac_op = '{rotl(k_reg, 17), MIX_C1, '0};
                    4'd5: mac_op = '{rotl(h2_reg ^ k_reg, 13) + h1_reg, LANE_MUL, MIX_C4};
                    default: mac_op = '0;
                endcase
            end
            ST_FIN:
            begin
                unique case (step_reg)
                    4'd0: mac_op = '{blk_lo, MIX_C1, '0};
                    4'd1: mac_op = '{rotl(k_reg, 15), MIX_C2, '0};
                    4'd2: mac_op = '{blk_hi, MIX_C2, '0};
                    4'd3: mac_op = '{rotl(k_reg, 17), MIX_C1, '0};
                    4'd4:
                    begin
                        t2 = h2_reg ^ ((fill_reg > 3'd4) ? k_reg : '0) ^ len_reg;
                        t1 = (h1_reg ^ len_reg) + t2;
                    end
                    4'd6: mac_op = '{h1_reg ^ (h1_reg >> 16), FIN_C5, '0};
                    4'd7: mac_op = '{h1_reg ^ (h1_reg >> 13), FIN_C6, '0};
                    4'd8: mac_op = '{h2_reg ^ (h2_reg >> 16), FIN_C5, '0};
                    4'd9: mac_op = '{h2_reg ^ (h2_reg >> 13), FIN_C6, '0};
                    default: mac_op = '0;
                endcase
            end
            default: mac_op = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        seed_next      = seed_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        block_next     = block_reg;
        fill_next      = fill_reg;
        open_next      = open_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        hash_next      = hash_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            seed_next = cfg_wr_data;
            if (!open_reg)
            begin
                h1_next = cfg_wr_data;
                h2_next = cfg_wr_data;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (has_byte || last))
                begin
                    open_next = 1'b1;
                    last_next = last;
                    step_next = '0;
                    if (has_byte)
                    begin
                        block_next = block_reg | ({{(BLOCK_W-BYTE_W){1'b0}}, byte_value}
                                                  << {fill_reg, 3'b000});
                        fill_next  = fill_reg + 1'b1;
                        len_next   = len_reg + 1'b1;
                    end
                    if (has_byte && (fill_reg == {FILL_W{1'b1}}))
                    begin
                        state_next = ST_MIX;
                    end
                    else if (last)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MIX:
            begin
                step_next = step_reg + 1'b1;
                unique case (step_reg)
                    4'd2, 4'd5:
                    begin
                        if (step_reg == 4'd2)
                        begin
                            h1_next = mac_y;
                        end
                        else
                        begin
                            h2_next = mac_y;
                        end
                    end
                    default: k_next = mac_y;
                endcase
                if (step_reg == MIX_LAST)
                begin
                    block_next = '0;
                    fill_next  = '0;
                    step_next  = '0;
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN:
            begin
                step_next = step_reg + 1'b1;
                unique case (step_reg)
                    4'd0, 4'd1, 4'd3: k_next = mac_y;
                    4'd2:
                    begin
                        h1_next = h1_reg ^ ((fill_reg != '0) ? k_reg : '0);
                        k_next  = mac_y;
                    end
                    4'd4:
                    begin
                        h1_next = t1;
                        h2_next = t2;
                    end
                    4'd5: h2_next = h2_reg + h1_reg;
                    4'd6, 4'd7: h1_next = mac_y;
                    4'd8:
                    begin
                        h1_next = h1_reg ^ (h1_reg >> 16);
                        h2_next = mac_y;
                    end
                    4'd9: h2_next = mac_y;
                    4'd10: h2_next = h2_reg ^ (h2_reg >> 16);
                    4'd11: h1_next = h1_reg + h2_reg;
                    default:
                    begin
                        step_next = step_reg;
                        if (!out_valid_reg || out_ready)
                        begin
                            hash_next      = {h2_reg + h1_reg, h1_reg};
                            out_valid_next = 1'b1;
                            h1_next        = seed_reg;
                            h2_next        = seed_reg;
                            len_next       = '0;
                            block_next     = '0;
                            fill_next      = '0;
                            open_next      = 1'b0;
                            last_next      = 1'b0;
                            step_next      = '0;
                            state_next     = ST_IDLE;
                        end
                    end
                endcase
                if (step_reg > FIN_LAST)
                begin
                    step_next = FIN_LAST;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            seed_reg      <= '0;
            h1_reg        <= '0;
            h2_reg        <= '0;
            len_reg       <= '0;
            block_reg     <= '0;
            fill_reg      <= '0;
            open_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            seed_reg      <= seed_next;
            h1_reg        <= h1_next;
            h2_reg        <= h2_next;
            len_reg       <= len_next;
            block_reg     <= block_next;
            fill_reg      <= fill_next;
            open_reg      <= open_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        hash_reg <= hash_next;
    end

endmodule

FILE: sv/m3h64_mac.sv
// Shared 32-bit multiply-add unit: low word of a*b plus c.
module m3h64_mac
    import m3h64_pkg::*;
(
    input  mac_op_t op,
    output word_t   result
);

    word_t product;

    assign product = op.mul_a * op.mul_b;
    assign result  = product + op.add_c;

endmodule

FILE: sv/m3h64_checker.sv
// Port-level assertion checker for the two-lane hash block, with its bind.
`include "murmur3_two_lane_hash64_macros.svh"

module m3h64_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        has_byte,
    input logic        last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] hash_value
);

    // Hold a result that has not been taken.
    `M3H_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(hash_value))

    // Finalize after the last transaction: input stays blocked.
    `M3H_ASSERT_NEXT(a_last_blocks, clk, rst_n, in_valid && in_ready && last, !in_ready)

    // Drop an empty non-last transaction without leaving idle.
    `M3H_ASSERT_NEXT(a_empty_idle, clk, rst_n, in_valid && in_ready && !has_byte && !last, in_ready)

    // Raise a result only at the end of a busy stretch.
    `M3H_ASSERT_NOW(a_result_after_busy, clk, rst_n, $rose(out_valid), !$past(in_ready) && in_ready)

endmodule

bind murmur3_two_lane_hash64 m3h64_checker u_m3h64_checker (.*);

FILE: tb/tb_murmur3_two_lane_hash64.sv
// Self-checking testbench for the two-lane 64-bit streaming hash block.
`timescale 1ns / 100ps

module tb_murmur3_two_lane_hash64;
    import m3h64_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int ITEMS_PER_PHASE = 200;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_val;
        logic               has;
        logic               fin;
        logic               typed_in;
        logic [BLOCK_W-1:0] digest;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [0:24] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 64'h0},
        '{8'hA5, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h5A, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h01, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h7F, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'hFE, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h55, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'hAA, 1'b1, 1'b1, 1'b0, 64'h0},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 64'h0},
        '{8'h12, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h34, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h56, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h78, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h9A, 1'b1, 1'b1, 1'b0, 64'h0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'hC3, 1'b0, 1'b1, 1'b0, 64'h0},
        '{8'hFE, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h01, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h7F, 1'b1, 1'b1, 1'b0, 64'h0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [BYTE_W-1:0]  byte_value;
    logic               has_byte;
    logic               last;
    logic               out_valid;
    logic               out_ready;
    logic [BLOCK_W-1:0] hash_value;
    logic               cfg_wr_en;
    logic [WORD_W-1:0]  cfg_wr_data;

    int in_idle_pct;
    int out_idle_pct;
    int cycle_count;
    int error_count;
    int items_sent;
    int hashes_checked;

    logic [BLOCK_W-1:0] digest_queue [$];

    word_t              hs_seed;
    word_t              hs_lane1;
    word_t              hs_lane2;
    logic [BLOCK_W-1:0] hs_block;
    int unsigned        hs_fill;
    word_t              hs_length;
    logic               hs_open;

    murmur3_two_lane_hash64 i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_value  (byte_value),
        .has_byte    (has_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hash_value  (hash_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic word_t rotl32(input word_t x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic word_t scramble_lo(input word_t k);
        word_t t;
        t = k * MIX_C1;
        t = rotl32(t, 15);
        return t * MIX_C2;
    endfunction

    function automatic word_t scramble_hi(input word_t k);
        word_t t;
        t = k * MIX_C2;
        t = rotl32(t, 17);
        return t * MIX_C1;
    endfunction

    function automatic word_t fmix32(input word_t h);
        word_t t;
        t = h ^ (h >> 16);
        t = t * FIN_C5;
        t = t ^ (t >> 13);
        t = t * FIN_C6;
        return t ^ (t >> 16);
    endfunction

    task automatic absorb_item(input logic [BYTE_W-1:0] b, input logic has, input logic fin,
                               output logic done, output logic [BLOCK_W-1:0] digest);
        word_t h1;
        word_t h2;
        done   = 1'b0;
        digest = '0;
        if (has || fin)
        begin
            hs_open = 1'b1;
            if (has)
            begin
                hs_block  = hs_block | ({56'b0, b} << (8 * hs_fill));
                hs_fill   = hs_fill + 1;
                hs_length = hs_length + 1;
                if (hs_fill >= 8)
                begin
                    hs_lane1 = hs_lane1 ^ scramble_lo(hs_block[31:0]);
                    hs_lane1 = rotl32(hs_lane1, 19);
                    hs_lane1 = hs_lane1 + hs_lane2;
                    hs_lane1 = hs_lane1 * LANE_MUL + MIX_C3;
                    hs_lane2 = hs_lane2 ^ scramble_hi(hs_block[63:32]);
                    hs_lane2 = rotl32(hs_lane2, 13);
                    hs_lane2 = hs_lane2 + hs_lane1;
                    hs_lane2 = hs_lane2 * LANE_MUL + MIX_C4;
                    hs_block = '0;
                    hs_fill  = 0;
                end
            end
            if (fin)
            begin
                h1 = hs_lane1;
                h2 = hs_lane2;
                if (hs_fill > 0)
                begin
                    h1 = h1 ^ scramble_lo(hs_block[31:0]);
                    if (hs_fill > 4)
                        h2 = h2 ^ scramble_hi(hs_block[63:32]);
                end
                h1 = h1 ^ hs_length;
                h2 = h2 ^ hs_length;
                h1 = h1 + h2;
                h2 = h2 + h1;
                h1 = fmix32(h1);
                h2 = fmix32(h2);
                h1 = h1 + h2;
                h2 = h2 + h1;
                digest    = {h2, h1};
                done      = 1'b1;
                hs_lane1  = hs_seed;
                hs_lane2  = hs_seed;
                hs_block  = '0;
                hs_fill   = 0;
                hs_length = '0;
                hs_open   = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [BLOCK_W-1:0] got,
                                   input logic [BLOCK_W-1:0] want);
        $display("MISMATCH %s: got %016h want %016h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic drive_item(input logic [BYTE_W-1:0] b, input logic has, input logic fin,
                              input logic typed_in, input logic [BLOCK_W-1:0] typed_digest);
        logic               done;
        logic [BLOCK_W-1:0] digest;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        has_byte   <= has;
        last       <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_item(b, has, fin, done, digest);
        if (done)
            digest_queue.insert(digest_queue.size(), typed_in ? typed_digest : digest);
        if (has || fin)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic seed_write(input word_t value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        hs_seed = value;
        if (!hs_open)
        begin
            hs_lane1 = value;
            hs_lane2 = value;
        end
    endtask

    task automatic emit_string();
        int                len;
        logic              end_bare;
        logic [BYTE_W-1:0] b;
        len      = ($urandom_range(4) == 0) ? $urandom_range(40, 21) : $urandom_range(20, 0);
        end_bare = (len == 0) || ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                drive_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
            if ($urandom_range(3) == 0)
                b = $urandom_range(1) ? 8'hFF : 8'h00;
            else
                b = 8'($urandom_range(255));
            drive_item(b, 1'b1, !end_bare && (i == len - 1), 1'b0, '0);
        end
        if (end_bare)
            drive_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= out_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_queue.size() == 0)
                report_mismatch("unexpected hash", hash_value, '0);
            else
            begin
                if (hash_value !== digest_queue[0])
                    report_mismatch("hash_value", hash_value, digest_queue[0]);
                void'(digest_queue.pop_front());
                hashes_checked++;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d hashes outstanding", cycle_count,
                 digest_queue.size());
        $display("tb_murmur3_two_lane_hash64 NOT OK");
        $finish;
    end

    initial
    begin
        word_t phase_seed [3];
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        byte_value     = '0;
        has_byte       = 1'b0;
        last           = 1'b0;
        out_ready      = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_idle_pct    = 31;
        out_idle_pct   = 86;
        error_count    = 0;
        items_sent     = 0;
        hashes_checked = 0;
        hs_seed        = '0;
        hs_lane1       = '0;
        hs_lane2       = '0;
        hs_block       = '0;
        hs_fill        = 0;
        hs_length      = '0;
        hs_open        = 1'b0;
        phase_seed[0]  = 32'hFFFF_FFFF;
        phase_seed[1]  = $urandom();
        phase_seed[2]  = 32'h0000_0001;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        seed_write('0);
        foreach (DIRECTED_ROWS[i])
            drive_item(DIRECTED_ROWS[i].byte_val, DIRECTED_ROWS[i].has, DIRECTED_ROWS[i].fin,
                       DIRECTED_ROWS[i].typed_in, DIRECTED_ROWS[i].digest);
        in_valid <= 1'b0;

        for (int phase = 0; phase < 3; phase++)
        begin
            int start_count;
            in_idle_pct  = (phase == 0) ? 31 : (phase == 1) ? 86 : 0;
            out_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 31 : 0;
            seed_write(phase_seed[phase]);
            start_count = items_sent;
            while (items_sent - start_count < ITEMS_PER_PHASE)
                emit_string();
            in_valid <= 1'b0;
        end

        wait_drained();
        $display("Run covered %0d transactions and %0d checked hashes, %0d mismatches",
                 items_sent, hashes_checked, error_count);
        $display("Seeds zero, all ones, one and %08h under three handshake idling mixes",
                 phase_seed[1]);
        if (error_count == 0)
            $display("tb_murmur3_two_lane_hash64 OK");
        else
            $display("tb_murmur3_two_lane_hash64 NOT OK");
        $finish;
    end

endmodule
